FILE: rtl/rpip_pkg.sv
// ----------------------------------------------------------------------------
// rpip_pkg
// Shared types, codes and constants of the radix prefixed integer parser.
// ----------------------------------------------------------------------------
package rpip_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // queue item operation codes
    localparam logic [2:0] OP_FEED        = 3'd0;
    localparam logic [2:0] OP_END         = 3'd1;
    localparam logic [2:0] OP_END_EMPTY   = 3'd2;
    localparam logic [2:0] OP_END_SHORT   = 3'd3;
    localparam logic [2:0] OP_END_NOWRITE = 3'd4;

    // radix codes
    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_BIN = 2'd1;
    localparam logic [1:0] RX_HEX = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // one classified byte or end-of-string marker
    typedef struct packed {
        logic [2:0] op;
        logic [1:0] radix;
        logic       is_ws;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       is_dig;
        logic [3:0] dval;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic                 success;
        logic                 saturated;
        logic                 value_written;
    } t_result;

endpackage

FILE: rtl/rpip_front.sv
// ----------------------------------------------------------------------------
// rpip_front
// Accepts string bytes, resolves the radix prefix and classifies each byte
// into a queue item for the digit engine.
// ----------------------------------------------------------------------------
module rpip_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_char_code,
    output logic               o_push,
    output rpip_pkg::t_item    o_item
);

    logic [1:0] r_char_count, n_char_count;
    logic [7:0] r_held_char,  n_held_char;
    logic [1:0] r_radix,      n_radix;
    logic       r_nowrite,    n_nowrite;

    function automatic rpip_pkg::t_item classify(input logic [7:0] c, input logic [1:0] rx);
        rpip_pkg::t_item it;
        logic [5:0]      dv;
        logic [4:0]      base;
        it = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            dv = 6'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            dv = 6'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            dv = 6'(c - 8'h37);
        end else begin
            dv = 6'h3F;
        end
        case (rx)
            rpip_pkg::RX_BIN: base = 5'd2;
            rpip_pkg::RX_HEX: base = 5'd16;
            default:          base = 5'd10;
        endcase
        it.op       = rpip_pkg::OP_FEED;
        it.radix    = rx;
        it.is_ws    = (c >= rpip_pkg::CH_TAB && c <= rpip_pkg::CH_CR) ||
                      (c == rpip_pkg::CH_SPACE);
        it.is_sign  = (c == rpip_pkg::CH_PLUS) || (c == rpip_pkg::CH_MINUS);
        it.is_minus = (c == rpip_pkg::CH_MINUS);
        it.is_zero  = (c == rpip_pkg::CH_ZERO);
        it.is_x     = (c == rpip_pkg::CH_LO_X) || (c == rpip_pkg::CH_UP_X);
        it.is_dig   = ({1'b0, dv} < {1'b0, base, 1'b0} >> 1);
        it.dval     = dv[3:0];
        return it;
    endfunction

    always_comb begin
        n_char_count = r_char_count;
        n_held_char  = r_held_char;
        n_radix      = r_radix;
        n_nowrite    = r_nowrite;
        o_push       = 1'b0;
        o_item       = classify(i_char_code, r_radix);
        if (i_accept) begin
            if (i_char_code != rpip_pkg::CH_NUL) begin
                case (r_char_count)
                    2'd0: begin
                        if (i_char_code == rpip_pkg::CH_ZERO) begin
                            n_char_count = 2'd1;
                        end else begin
                            n_char_count = 2'd3;
                            o_push       = 1'b1;
                            o_item       = classify(i_char_code, rpip_pkg::RX_DEC);
                        end
                    end
                    2'd1: begin
                        n_held_char  = i_char_code;
                        n_char_count = 2'd2;
                    end
                    2'd2: begin
                        n_char_count = 2'd3;
                        if (r_held_char == rpip_pkg::CH_LO_B ||
                            r_held_char == rpip_pkg::CH_UP_B) begin
                            n_radix = rpip_pkg::RX_BIN;
                            o_push  = 1'b1;
                            o_item  = classify(i_char_code, rpip_pkg::RX_BIN);
                        end else if (r_held_char == rpip_pkg::CH_LO_X ||
                                     r_held_char == rpip_pkg::CH_UP_X) begin
                            n_radix = rpip_pkg::RX_HEX;
                            o_push  = 1'b1;
                            o_item  = classify(i_char_code, rpip_pkg::RX_HEX);
                        end else begin
                            // leading zero with unknown prefix: drop the rest
                            n_nowrite = 1'b1;
                        end
                    end
                    default: begin
                        o_push = !r_nowrite;
                    end
                endcase
            end else begin
                o_push = 1'b1;
                case (r_char_count)
                    2'd0: begin
                        o_item.op = rpip_pkg::OP_END_EMPTY;
                    end
                    2'd1: begin
                        // a lone "0" reads as decimal zero
                        o_item.op     = rpip_pkg::OP_END_SHORT;
                        o_item.is_dig = 1'b1;
                        o_item.dval   = 4'd0;
                    end
                    2'd2: begin
                        o_item    = classify(r_held_char, rpip_pkg::RX_DEC);
                        o_item.op = rpip_pkg::OP_END_SHORT;
                    end
                    default: begin
                        o_item.op = r_nowrite ? rpip_pkg::OP_END_NOWRITE : rpip_pkg::OP_END;
                    end
                endcase
                n_char_count = 2'd0;
                n_held_char  = '0;
                n_radix      = rpip_pkg::RX_DEC;
                n_nowrite    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= 2'd0;
            r_held_char  <= '0;
            r_radix      <= rpip_pkg::RX_DEC;
            r_nowrite    <= 1'b0;
        end else begin
            r_char_count <= n_char_count;
            r_held_char  <= n_held_char;
            r_radix      <= n_radix;
            r_nowrite    <= n_nowrite;
        end
    end

endmodule

FILE: rtl/rpip_queue.sv
// ----------------------------------------------------------------------------
// rpip_queue
// Short item queue between the byte classifier and the digit engine.
// ----------------------------------------------------------------------------
module rpip_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rpip_pkg::t_item      i_item,
    input  logic                 i_pop,
    output rpip_pkg::t_item      o_item,
    output rpip_pkg::t_q_status  o_status
);

    rpip_pkg::t_item r_mem [rpip_pkg::Q_DEPTH];

    logic [rpip_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [rpip_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [rpip_pkg::Q_CNT_W-1:0] r_count,  n_count;
    logic                         do_push;
    logic                         do_pop;

    localparam logic [rpip_pkg::Q_PTR_W-1:0] LAST = rpip_pkg::Q_PTR_W'(rpip_pkg::Q_DEPTH - 1);
    localparam logic [rpip_pkg::Q_CNT_W-1:0] FULL = rpip_pkg::Q_CNT_W'(rpip_pkg::Q_DEPTH);

    assign o_status.full  = (r_count == FULL);
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: rtl/rpip_back.sv
// ----------------------------------------------------------------------------
// rpip_back
// Digit engine: runs the strtol-style parse over classified items and
// forms the result in the output register.
// ----------------------------------------------------------------------------
module rpip_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rpip_pkg::t_item     i_item,
    input  logic                i_signed_mode,
    input  logic                i_out_stall,
    output logic                o_pop,
    output logic                o_out_valid,
    output rpip_pkg::t_result   o_result
);

    localparam int VW = rpip_pkg::VALUE_WIDTH;
    localparam int OW = rpip_pkg::OUT_WIDTH;

    localparam logic [2:0] PH_WS     = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO1  = 3'd2;
    localparam logic [2:0] PH_XPFX   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_JUNK   = 3'd5;

    localparam logic [VW-1:0] HALF = {1'b1, {(VW-1){1'b0}}};

    logic [2:0]    r_phase,    n_phase;
    logic          r_negative, n_negative;
    logic [VW-1:0] r_acc,      n_acc;
    logic          r_overflow, n_overflow;
    logic          r_digit,    n_digit;
    logic          r_junk,     n_junk;

    logic          r_out_valid, n_out_valid;
    logic [OW-1:0] r_value,     n_value;
    logic          r_success,   n_success;
    logic          r_saturated, n_saturated;
    logic          r_written,   n_written;

    logic            load_ok;
    logic            is_end;
    logic            first;
    logic            take;
    logic [VW+3:0]   acc_x;
    logic [VW+3:0]   prod;
    logic [VW-1:0]   val;
    logic [VW-1:0]   lim;
    logic [VW+OW-1:0] val_ext;

    assign load_ok = !r_out_valid || !i_out_stall;
    assign is_end  = (i_item.op != rpip_pkg::OP_FEED);
    assign o_pop   = i_q_valid && (!is_end || load_ok);

    // acc * radix + digit, by shifts and adds
    always_comb begin
        acc_x = {4'b0, r_acc};
        case (i_item.radix)
            rpip_pkg::RX_BIN: prod = acc_x << 1;
            rpip_pkg::RX_HEX: prod = acc_x << 4;
            default:          prod = (acc_x << 3) + (acc_x << 1);
        endcase
        prod = prod + {{VW{1'b0}}, i_item.dval};
    end

    always_comb begin
        n_phase     = r_phase;
        n_negative  = r_negative;
        n_acc       = r_acc;
        n_overflow  = r_overflow;
        n_digit     = r_digit;
        n_junk      = r_junk;
        n_out_valid = r_out_valid;
        n_value     = r_value;
        n_success   = r_success;
        n_saturated = r_saturated;
        n_written   = r_written;
        first       = 1'b0;
        take        = 1'b0;
        val         = '0;
        lim         = r_negative ? HALF : HALF - 1'b1;
        val_ext     = '0;

        if (load_ok) begin
            n_out_valid = 1'b0;
        end

        if (o_pop && !is_end) begin
            case (r_phase)
                PH_WS: begin
                    if (i_item.is_ws) begin
                        n_phase = r_phase;
                    end else if (i_item.is_sign) begin
                        n_negative = i_item.is_minus;
                        n_phase    = PH_SIGNED;
                    end else begin
                        first = 1'b1;
                    end
                end
                PH_SIGNED: begin
                    first = 1'b1;
                end
                PH_ZERO1: begin
                    if (i_item.is_x) begin
                        n_phase = PH_XPFX;
                    end else if (i_item.is_dig) begin
                        take    = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_JUNK;
                        n_junk  = 1'b1;
                    end
                end
                PH_XPFX, PH_DIGITS: begin
                    if (i_item.is_dig) begin
                        take    = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_JUNK;
                        n_junk  = 1'b1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (first) begin
                // a leading '0' in hex may open an inner 0x prefix
                if (i_item.radix == rpip_pkg::RX_HEX && i_item.is_zero) begin
                    take    = 1'b1;
                    n_phase = PH_ZERO1;
                end else if (i_item.is_dig) begin
                    take    = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_JUNK;
                    n_junk  = 1'b1;
                end
            end

            if (take) begin
                n_digit = 1'b1;
                if (!r_overflow) begin
                    if (prod[VW+3:VW] != 4'd0) begin
                        n_overflow = 1'b1;
                        n_acc      = '1;
                    end else begin
                        n_acc = prod[VW-1:0];
                    end
                end
            end
        end

        if (o_pop && is_end) begin
            n_success   = 1'b0;
            n_saturated = 1'b0;
            n_written   = 1'b1;
            case (i_item.op)
                rpip_pkg::OP_END_EMPTY: begin
                    n_success = 1'b1;
                end
                rpip_pkg::OP_END_SHORT: begin
                    val       = i_item.is_dig ? {{(VW-4){1'b0}}, i_item.dval} : '0;
                    n_success = i_item.is_dig;
                end
                rpip_pkg::OP_END_NOWRITE: begin
                    n_written = 1'b0;
                end
                default: begin
                    if (i_signed_mode) begin
                        if (r_overflow || r_acc > lim) begin
                            n_saturated = 1'b1;
                            val         = lim;
                        end else begin
                            val = r_negative ? (~r_acc + 1'b1) : r_acc;
                        end
                    end else begin
                        if (r_overflow) begin
                            n_saturated = 1'b1;
                            val         = '1;
                        end else begin
                            val = r_negative ? (~r_acc + 1'b1) : r_acc;
                        end
                    end
                    n_success = r_digit && !r_junk && (r_phase != PH_XPFX);
                end
            endcase
            val_ext     = {{OW{1'b0}}, val};
            n_value     = val_ext[OW-1:0];
            n_out_valid = 1'b1;
            // clear the parse state for the next string
            n_phase    = PH_WS;
            n_negative = 1'b0;
            n_acc      = '0;
            n_overflow = 1'b0;
            n_digit    = 1'b0;
            n_junk     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WS;
            r_negative  <= 1'b0;
            r_acc       <= '0;
            r_overflow  <= 1'b0;
            r_digit     <= 1'b0;
            r_junk      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_negative  <= n_negative;
            r_acc       <= n_acc;
            r_overflow  <= n_overflow;
            r_digit     <= n_digit;
            r_junk      <= n_junk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_success   <= n_success;
        r_saturated <= n_saturated;
        r_written   <= n_written;
    end

    assign o_out_valid            = r_out_valid;
    assign o_result.value         = r_value;
    assign o_result.success       = r_success;
    assign o_result.saturated     = r_saturated;
    assign o_result.value_written = r_written;

endmodule

FILE: rtl/radix_prefixed_integer_parser_core.sv
// ----------------------------------------------------------------------------
// radix_prefixed_integer_parser_core
// Streaming ASCII integer parser with 0b/0x radix prefix, sign, white space
// skipping and overflow saturation; one result per zero-terminated string.
//
//   channel   direction  handshake                  payload
//   input     in         i_valid / o_stall          i_char_code
//   result    out        o_valid / i_stall          o_value, o_success,
//                                                   o_saturated, o_value_written
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_signed_mode
//
// One byte is taken per cycle while o_stall is low; a result passes through
// the queue stage, then the output register, after its zero byte is accepted.
// The digit engine's multiply-by-radix plus add sets the one-byte-per-cycle
// pace. o_stall rises only while the two-entry queue is full, which happens
// when results back up behind i_stall. Reset is synchronous, active low, and
// sets signed mode.
// ----------------------------------------------------------------------------
module radix_prefixed_integer_parser_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [7:0]                    i_char_code,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic [rpip_pkg::OUT_WIDTH-1:0] o_value,
    output logic                          o_success,
    output logic                          o_saturated,
    output logic                          o_value_written,
    input  logic                          i_stall,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_signed_mode,
    output logic                          o_cfg_ready
);

    logic                 r_signed_mode;
    logic                 accept;
    logic                 q_push;
    logic                 q_pop;
    rpip_pkg::t_item      front_item;
    rpip_pkg::t_item      q_item;
    rpip_pkg::t_q_status  q_status;
    rpip_pkg::t_result    result;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_status.full;
    assign accept      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_signed_mode <= i_cfg_signed_mode;
        end
    end

    rpip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .o_push      (q_push),
        .o_item      (front_item)
    );

    rpip_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (front_item),
        .i_pop    (q_pop),
        .o_item   (q_item),
        .o_status (q_status)
    );

    rpip_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (!q_status.empty),
        .i_item        (q_item),
        .i_signed_mode (r_signed_mode),
        .i_out_stall   (i_stall),
        .o_pop         (q_pop),
        .o_out_valid   (o_valid),
        .o_result      (result)
    );

    assign o_value         = result.value;
    assign o_success       = result.success;
    assign o_saturated     = result.saturated;
    assign o_value_written = result.value_written;

    a_queue_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    a_no_phantom_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_push && q_status.empty && !o_valid) |=> !o_valid)
        else $error("result appeared with no queued item");

    a_nowrite_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_value_written) |-> (!o_success && !o_saturated && o_value == '0))
        else $error("rejected string carries a value or flags");

endmodule
